/* rtl/core/falu_pkg.sv */
// Package: shared constants and opcode/status codes for the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package falu_pkg;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int PORT_W         = 32;

	localparam logic [3:0] K_ADD = 4'd0;
	localparam logic [3:0] K_SUB = 4'd1;
	localparam logic [3:0] K_MUL = 4'd2;
	localparam logic [3:0] K_DIV = 4'd3;
	localparam logic [3:0] K_GT  = 4'd4;
	localparam logic [3:0] K_LT  = 4'd5;
	localparam logic [3:0] K_GE  = 4'd6;
	localparam logic [3:0] K_LE  = 4'd7;
	localparam logic [3:0] K_EQ  = 4'd8;
	localparam logic [3:0] K_NE  = 4'd9;
	localparam logic [3:0] K_NOT = 4'd10;
	localparam logic [3:0] K_INC = 4'd11;
	localparam logic [3:0] K_DEC = 4'd12;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/falu_front.sv */
// Input stage: simple ops, full product and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module falu_front import falu_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF,
	parameter int N  = DW + FB
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld,
	input  wire logic [3:0]           kind,
	input  wire logic [PORT_W-1:0]    a_in,
	input  wire logic [PORT_W-1:0]    b_in,
	output logic                      vld_s1,
	output logic [3:0]                kind_s1,
	output logic [DW-1:0]             res_s1,
	output logic [1:0]                st_s1,
	output logic signed [2*DW-1:0]    prod_s1,
	output logic [DW-1:0]             rem_s1,
	output logic [N-1:0]              dq_s1,
	output logic [DW-1:0]             dsr_s1,
	output logic                      neg_s1
);
	logic signed [DW-1:0]   sa, sb;
	logic signed [2*DW-1:0] prod;
	logic [DW:0]            sum, dif, inc, dec, arr;
	logic [DW-1:0]          abs_a, abs_b, res;
	logic [1:0]             st;
	logic                   use_arr;

	assign sa   = a_in[DW-1:0];
	assign sb   = b_in[DW-1:0];
	assign prod = sa * sb;
	assign sum  = {sa[DW-1], sa} + {sb[DW-1], sb};
	assign dif  = {sa[DW-1], sa} - {sb[DW-1], sb};
	assign inc  = {sa[DW-1], sa} + (DW+1)'(1);
	assign dec  = {sa[DW-1], sa} - (DW+1)'(1);
	assign abs_a = sa[DW-1] ? (~sa + DW'(1)) : sa;
	assign abs_b = sb[DW-1] ? (~sb + DW'(1)) : sb;

	always_comb begin
		res     = '0;
		st      = ST_OK;
		use_arr = 1'b0;
		arr     = '0;
		case (kind)
			K_ADD: begin use_arr = 1'b1; arr = sum; end
			K_SUB: begin use_arr = 1'b1; arr = dif; end
			K_INC: begin use_arr = 1'b1; arr = inc; end
			K_DEC: begin use_arr = 1'b1; arr = dec; end
			K_DIV: if (sb == '0) st = ST_DIV0;
			K_GT:  res = DW'(sa > sb);
			K_LT:  res = DW'(sa < sb);
			K_GE:  res = DW'(sa >= sb);
			K_LE:  res = DW'(sa <= sb);
			K_EQ:  res = DW'(sa == sb);
			K_NE:  res = DW'(sa != sb);
			K_NOT: res = DW'(sa == '0);
			default: res = '0;
		endcase
		if (use_arr) begin
			if (arr[DW] != arr[DW-1]) st = ST_OVF;
			else res = arr[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			res_s1  <= res;
			st_s1   <= st;
			prod_s1 <= prod;
			rem_s1  <= '0;
			dq_s1   <= {abs_a, {FB{1'b0}}};
			dsr_s1  <= abs_b;
			neg_s1  <= sa[DW-1] ^ sb[DW-1];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/falu_div_cell.sv */
// Divider cell: one restoring quotient bit, passes the rest of the word along.
`timescale 1ns / 1ps
`default_nettype none
module falu_div_cell import falu_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int N  = DATA_WIDTH_DEF + FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_i,
	input  wire logic [3:0]           kind_i,
	input  wire logic [DW-1:0]        res_i,
	input  wire logic [1:0]           st_i,
	input  wire logic [2*DW-1:0]      prod_i,
	input  wire logic [DW-1:0]        rem_i,
	input  wire logic [N-1:0]         dq_i,
	input  wire logic [DW-1:0]        dsr_i,
	input  wire logic                 neg_i,
	output logic                      vld_q,
	output logic [3:0]                kind_q,
	output logic [DW-1:0]             res_q,
	output logic [1:0]                st_q,
	output logic [2*DW-1:0]           prod_q,
	output logic [DW-1:0]             rem_q,
	output logic [N-1:0]              dq_q,
	output logic [DW-1:0]             dsr_q,
	output logic                      neg_q
);
	logic [DW:0] t, d;
	logic        qb;

	assign t  = {rem_i, dq_i[N-1]};
	assign d  = t - {1'b0, dsr_i};
	assign qb = (t >= {1'b0, dsr_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= kind_i;
			res_q  <= res_i;
			st_q   <= st_i;
			prod_q <= prod_i;
			rem_q  <= qb ? d[DW-1:0] : t[DW-1:0];
			dq_q   <= {dq_i[N-2:0], qb};
			dsr_q  <= dsr_i;
			neg_q  <= neg_i;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/falu_back.sv */
// Output stage: product rounding, quotient sign, range check, output register.
`timescale 1ns / 1ps
`default_nettype none
module falu_back import falu_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF,
	parameter int N  = DW + FB
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_i,
	input  wire logic [3:0]           kind_i,
	input  wire logic [DW-1:0]        res_i,
	input  wire logic [1:0]           st_i,
	input  wire logic [2*DW-1:0]      prod_i,
	input  wire logic [N-1:0]         quo_i,
	input  wire logic                 neg_i,
	output logic                      vld_q,
	output logic [PORT_W-1:0]         res_q,
	output logic [1:0]                st_q
);
	localparam int W2 = 2 * DW + 1;
	localparam logic [W2-1:0] LIM_N = W2'(1) << (DW - 1);
	localparam logic [W2-1:0] LIM_P = LIM_N - W2'(1);
	localparam logic [W2-1:0] HALF  = W2'(1) << (FB - 1);

	logic [2*DW-1:0] pmag;
	logic [W2-1:0]   rnd, mag;
	logic            neg, fits;
	logic [DW-1:0]   mres, res;
	logic [1:0]      st;

	assign pmag = prod_i[2*DW-1] ? (~prod_i + (2*DW)'(1)) : prod_i;
	assign rnd  = {1'b0, pmag} + HALF;

	always_comb begin
		res = res_i;
		st  = st_i;
		if (kind_i == K_MUL) begin
			mag = rnd >> FB;
			neg = prod_i[2*DW-1];
		end else begin
			mag = W2'(quo_i);
			neg = neg_i;
		end
		fits = neg ? (mag <= LIM_N) : (mag <= LIM_P);
		mres = neg ? (~mag[DW-1:0] + DW'(1)) : mag[DW-1:0];
		if (kind_i == K_MUL || (kind_i == K_DIV && st_i == ST_OK)) begin
			if (fits) begin
				res = mres;
			end else begin
				res = '0;
				st  = ST_OVF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= PORT_W'(signed'(res));
			st_q  <= st;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/fixed_point_alu_unit.sv */
// Top level: fixed-point ALU built as a pipeline with a row of divider cells.
// Throughput: one word per cycle while the sink does not hold the output; the row
// of restoring divider cells, one quotient bit per cell, sets the latency.
// The whole pipeline advances unless the output word is held by the sink.
// arst_n clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_unit import falu_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // operand_a[31:0], operand_b[63:32]
	input  wire logic [3:0]  s_tuser,  // kind[3:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // result_value[31:0], status[33:32], zero pad
);
	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int N  = DW + FB;

	logic en;
	logic [1:0] st_out;
	logic [PORT_W-1:0] res_out;

	logic              vld  [N+1];
	logic [3:0]        kind [N+1];
	logic [DW-1:0]     res  [N+1];
	logic [1:0]        st   [N+1];
	logic [2*DW-1:0]   prod [N+1];
	logic [DW-1:0]     rem  [N+1];
	logic [N-1:0]      dq   [N+1];
	logic [DW-1:0]     dsr  [N+1];
	logic              neg  [N+1];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tdata  = {6'b0, st_out, res_out};

	falu_front #(.DW(DW), .FB(FB), .N(N)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(s_tvalid), .kind(s_tuser),
		.a_in(s_tdata[31:0]), .b_in(s_tdata[63:32]),
		.vld_s1(vld[0]), .kind_s1(kind[0]), .res_s1(res[0]), .st_s1(st[0]),
		.prod_s1(prod[0]), .rem_s1(rem[0]), .dq_s1(dq[0]), .dsr_s1(dsr[0]),
		.neg_s1(neg[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		falu_div_cell #(.DW(DW), .N(N)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(vld[i]), .kind_i(kind[i]), .res_i(res[i]), .st_i(st[i]),
			.prod_i(prod[i]), .rem_i(rem[i]), .dq_i(dq[i]), .dsr_i(dsr[i]),
			.neg_i(neg[i]),
			.vld_q(vld[i+1]), .kind_q(kind[i+1]), .res_q(res[i+1]), .st_q(st[i+1]),
			.prod_q(prod[i+1]), .rem_q(rem[i+1]), .dq_q(dq[i+1]), .dsr_q(dsr[i+1]),
			.neg_q(neg[i+1])
		);
	end

	falu_back #(.DW(DW), .FB(FB), .N(N)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld[N]), .kind_i(kind[N]), .res_i(res[N]), .st_i(st[N]),
		.prod_i(prod[N]), .quo_i(dq[N]), .neg_i(neg[N]),
		.vld_q(m_tvalid), .res_q(res_out), .st_q(st_out)
	);

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st_out != 2'd3))
		else $error("illegal status code");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st_out != ST_OK) |-> (res_out == '0))
		else $error("error result is not zero");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(vld[0]) && $stable(vld[N])))
		else $error("pipeline moved while output stalled");
endmodule
`default_nettype wire

/* tb/sv/fixed_point_alu_unit_tb.sv */
// Testbench for the fixed-point ALU: random and directed operations checked against a behavioral predictor.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_unit_tb;
	import falu_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] a;
		logic [31:0] b;
	} alu_op_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} alu_res_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic [3:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [39:0] m_tdata;

	alu_op_t pending_ops[$];
	alu_res_t expected_results[$];
	int errors;
	bit stim_done;
	bit sender_hold;
	bit sink_hold;
	int sink_stall_cycles;
	bit no_idle;
	int idle_cycles;
	int driven_count;

	fixed_point_alu_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic alu_res_t compute_alu(alu_op_t op);
		alu_res_t res;
		longint sa;
		longint sb;
		longint r;
		longint p;
		bit arith;
		sa = longint'(signed'(op.a));
		sb = longint'(signed'(op.b));
		r = 0;
		arith = 1'b0;
		res.status = ST_OK;
		case (op.kind)
			K_ADD: begin r = sa + sb; arith = 1; end
			K_SUB: begin r = sa - sb; arith = 1; end
			K_MUL: begin
				p = sa * sb;
				p = (p >= 0) ? p + (64'sd1 <<< (FRAC - 1)) : p - (64'sd1 <<< (FRAC - 1));
				r = p / (64'sd1 <<< FRAC);
				arith = 1;
			end
			K_DIV: begin
				if (sb == 0) res.status = ST_DIV0;
				else begin
					r = (sa * (64'sd1 <<< FRAC)) / sb;
					arith = 1;
				end
			end
			K_GT: r = longint'(sa > sb);
			K_LT: r = longint'(sa < sb);
			K_GE: r = longint'(sa >= sb);
			K_LE: r = longint'(sa <= sb);
			K_EQ: r = longint'(sa == sb);
			K_NE: r = longint'(sa != sb);
			K_NOT: r = longint'(sa == 0);
			K_INC: begin r = sa + 1; arith = 1; end
			K_DEC: begin r = sa - 1; arith = 1; end
			default: r = 0;
		endcase
		if (arith && (r > 64'sd2147483647 || r < -64'sd2147483648)) begin
			r = 0;
			res.status = ST_OVF;
		end
		res.value = r[31:0];
		return res;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF - $urandom_range(0, 3);
			1: return 32'h80000000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 3) - 1;
			3: return signed'($urandom_range(0, 8192)) - 4096;
			4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
		alu_op_t op;
		op.kind = kind;
		op.a = a;
		op.b = b;
		pending_ops.push_back(op);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			driven_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(compute_alu({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
				driven_count <= driven_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() > 0 && !sender_hold
						&& (no_idle || $urandom_range(0, 99) >= 24)) begin
					alu_op_t op;
					op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= op.kind;
					s_tdata <= {op.b, op.a};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				alu_res_t got;
				alu_res_t exp_res;
				got.value = m_tdata[31:0];
				got.status = m_tdata[33:32];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word value=%h status=%0d", $time, got.value,
						got.status);
					errors++;
				end else begin
					exp_res = expected_results.pop_front();
					if (got.value !== exp_res.value)
						begin
						$display("%0t: value mismatch expected %h actual %h", $time,
							exp_res.value, got.value);
						errors++;
					end
					if (got.status !== exp_res.status) begin
						$display("%0t: status mismatch expected %0d actual %0d", $time,
							exp_res.status, got.status);
						errors++;
					end
				end
			end
			if (sink_stall_cycles > 0) begin
				sink_stall_cycles--;
				m_tready <= 1'b0;
			end else if (sink_hold) begin
				sink_stall_cycles = 150;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || $urandom_range(0, 99) >= 24;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] edges[6];
		int n;
		errors = 0;
		stim_done = 0;
		sender_hold = 0;
		sink_hold = 0;
		sink_stall_cycles = 0;
		no_idle = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		m_tready = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		edges = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h1, 32'h100};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every op, extremes, overflow, divide by zero, unused opcodes
		for (int k = 0; k < 16; k++) add_op(k[3:0], edges[k % 6], edges[(k + 2) % 6]);
		add_op(K_ADD, 32'h7FFFFFFF, 32'h1);
		add_op(K_SUB, 32'h80000000, 32'h1);
		add_op(K_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF);
		add_op(K_MUL, 32'h00000180, 32'hFFFFFF01);
		add_op(K_DIV, 32'h80000000, 32'hFFFFFFFF);
		add_op(K_DIV, 32'h12345678, 32'h0);
		add_op(K_INC, 32'h7FFFFFFF, 32'h0);
		add_op(K_DEC, 32'h80000000, 32'hFFFFFFFF);
		add_op(K_NOT, 32'h0, 32'h5);
		wait (pending_ops.size() == 0);

		// receiver holds off long while sender keeps offering
		for (int i = 0; i < 80; i++)
			add_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
		@(posedge clk);
		sink_hold <= 1'b1;
		@(posedge clk);
		sink_hold <= 1'b0;
		wait (pending_ops.size() == 0);

		// sender pauses until every result has come
		sender_hold = 1;
		wait (expected_results.size() == 0 && !s_tvalid);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sender_hold = 0;

		// stretch with no idling
		no_idle = 1;
		for (int i = 0; i < 100; i++)
			add_op(4'($urandom_range(0, 12)), rand_operand(), rand_operand());
		wait (pending_ops.size() == 0);
		no_idle = 0;

		n = 0;
		while (n < 250) begin
			add_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
			n++;
		end
		wait (pending_ops.size() == 0);
		@(posedge clk);
		wait (!s_tvalid);
		stim_done = 1;
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* fixed_point_alu_unit.f */
rtl/core/falu_pkg.sv
rtl/core/falu_front.sv
rtl/core/falu_div_cell.sv
rtl/core/falu_back.sv
rtl/core/fixed_point_alu_unit.sv
tb/sv/fixed_point_alu_unit_tb.sv
